// ----- hw/rtl/hbp_pkg.sv -----
// shared types and constants for the huffman bit packer
// no dependencies; imported by the top, the checker and the bench
`default_nettype none

package hbp_pkg;

  // request kind carried on the input side band
  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_e;

  localparam int unsigned ByteBits   = 8;
  localparam int unsigned CodeW      = 32;
  localparam int unsigned LenW       = 6;
  localparam int unsigned SymW       = 8;
  localparam int unsigned PendW      = 7;
  localparam int unsigned MaxCodeLen = 32;
  localparam int unsigned LenCap     = (MaxCodeLen < CodeW) ? MaxCodeLen : CodeW;

  // request and result bus layouts, lowest bit first
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned EntryW   = CodeW + LenW;
  localparam int unsigned MaxBytes = 4;

endpackage

`default_nettype wire

// ----- hw/rtl/hbp_ram.sv -----
// generic single port ram with registered read data
// depends on nothing; one access per cycle, write or read
`default_nettype none

module hbp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire                     re_i,
  input  wire [$clog2(Depth)-1:0] addr_i,
  input  wire [Width-1:0]         wdata_i,
  output logic [Width-1:0]        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/huffman_bit_packer_top.sv -----
// huffman bit packer: code table, bit accumulator and byte output stage
// depends on hbp_pkg and hbp_ram
//
// usage: requests arrive on the s_axis channel, the kind in tuser. a load
// request writes one symbol's code word and length into the code table. an
// encode request reads its symbol's entry and appends the code, first bit
// first, to the bit accumulator; each full byte leaves on m_axis with the
// earliest bit in bit 7 and valid_bits 8. a flush request sends the
// leftover 1..7 bits left-aligned, zero padded, with their count. tlast
// marks the final byte that one request causes; requests that cause no
// byte give nothing on m_axis.
// the table is read as a request enters the accumulator stage, and the
// output register loads from that stage once the stage may advance; the
// bytes of a request leave m_axis from the output register.
// throughput: one request per cycle while each yields at most one byte
// and m_axis does not stall; a request yielding several bytes (up to
// four) holds the single output register until all of them have left.
// reset clears the accumulator and the output stage; the table holds
// nothing defined until loaded. when m_axis stalls the output byte holds,
// requests yielding no byte keep flowing, the first one yielding a byte
// waits in the accumulator stage and s_axis then deasserts tready.
`default_nettype none

module huffman_bit_packer_top #(
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // symbol [7:0], code_word [39:8], code_length [45:40], zero [47:46]
  input  wire [hbp_pkg::InDataW-1:0]     s_axis_tdata,
  // func [1:0]
  input  wire [1:0]                      s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // out_byte [7:0], valid_bits [11:8], zero [15:12]
  output logic [hbp_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                           m_axis_tlast
);

  import hbp_pkg::*;

  localparam int unsigned AddrW = $clog2(SYMBOL_COUNT);

  // input field split
  logic [SymW-1:0]  in_sym;
  logic [CodeW-1:0] in_code;
  logic [LenW-1:0]  in_len;
  logic [LenW-1:0]  in_len_sat;
  logic             in_range;
  logic             in_acc;
  logic             tbl_we;
  logic             tbl_re;

  assign in_sym   = s_axis_tdata[7:0];
  assign in_code  = s_axis_tdata[39:8];
  assign in_len   = s_axis_tdata[45:40];
  assign in_range = ({1'b0, in_sym} < 9'(SYMBOL_COUNT));
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_len_sat = (in_len > LenW'(LenCap)) ? LenW'(LenCap) : in_len;
  assign tbl_we = in_acc && in_range && (s_axis_tuser == FUNC_LOAD);
  assign tbl_re = in_acc && in_range && (s_axis_tuser == FUNC_ENCODE);

  logic [EntryW-1:0] tbl_rdata;

  hbp_ram #(
    .Width(EntryW),
    .Depth(SYMBOL_COUNT)
  ) u_code_tbl (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .re_i   (tbl_re),
    .addr_i (in_sym[AddrW-1:0]),
    .wdata_i({in_len_sat, in_code}),
    .rdata_o(tbl_rdata)
  );

  // accumulator stage
  logic             s1_valid_q, s1_valid_d;
  logic             s1_enc_q, s1_enc_d;
  logic             s1_flush_q, s1_flush_d;
  logic [PendW-1:0] pend_q, pend_d;
  logic [2:0]       pcnt_q, pcnt_d;

  // output stage
  logic [CodeW-1:0] ob_data_q, ob_data_d;
  logic [2:0]       ob_cnt_q, ob_cnt_d;
  logic [3:0]       ob_vb_q, ob_vb_d;

  logic [LenW-1:0]        e_len;
  logic [CodeW:0]         e_mask;
  logic [PendW+CodeW-1:0] e_acc;
  logic [LenW-1:0]        e_total;
  logic [2:0]             e_rem;
  logic [CodeW-1:0]       e_full;
  logic [ByteBits-1:0]    e_keep;
  logic [ByteBits-1:0]    f_byte;
  logic [2:0]             s1_nb;
  logic                   ob_free;
  logic                   s1_adv;
  logic                   out_acc;
  logic [1:0]             ob_cm1;

  always_comb begin
    e_len   = tbl_rdata[EntryW-1:CodeW];
    e_mask  = ((CodeW+1)'(1) << e_len) - (CodeW+1)'(1);
    e_acc   = ((PendW+CodeW)'(pend_q) << e_len)
            | (PendW+CodeW)'(tbl_rdata[CodeW-1:0] & e_mask[CodeW-1:0]);
    e_total = LenW'(pcnt_q) + e_len;
    e_rem   = e_total[2:0];
    e_full  = CodeW'(e_acc >> e_rem);
    e_keep  = (ByteBits'(1) << e_rem) - ByteBits'(1);
    f_byte  = ByteBits'(pend_q) << (4'd8 - {1'b0, pcnt_q});
  end

  always_comb begin
    s1_nb = 3'd0;
    if (s1_enc_q) begin
      s1_nb = e_total[5:3];
    end else if (s1_flush_q && (pcnt_q != 3'd0)) begin
      s1_nb = 3'd1;
    end
  end

  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign ob_free       = (ob_cnt_q == 3'd0) || ((ob_cnt_q == 3'd1) && m_axis_tready);
  assign s1_adv        = s1_valid_q && ((s1_nb == 3'd0) || ob_free);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_enc_d   = s1_enc_q;
    s1_flush_d = s1_flush_q;
    pend_d     = pend_q;
    pcnt_d     = pcnt_q;
    ob_data_d  = ob_data_q;
    ob_cnt_d   = ob_cnt_q;
    ob_vb_d    = ob_vb_q;

    if (out_acc) begin
      ob_cnt_d = ob_cnt_q - 3'd1;
    end

    if (s1_adv) begin
      s1_valid_d = 1'b0;
      if (s1_enc_q) begin
        pend_d = e_acc[PendW-1:0] & e_keep[PendW-1:0];
        pcnt_d = e_rem;
      end else if (s1_flush_q) begin
        pend_d = '0;
        pcnt_d = '0;
      end
      // the output register is only touched by a request that yields bytes
      if (s1_nb != 3'd0) begin
        ob_cnt_d  = s1_nb;
        ob_data_d = s1_enc_q ? e_full : CodeW'(f_byte);
        ob_vb_d   = s1_enc_q ? 4'd8 : {1'b0, pcnt_q};
      end
    end

    // all requests pass the accumulator stage; encode needs a valid symbol
    if (in_acc) begin
      s1_valid_d = 1'b1;
      s1_enc_d   = in_range && (s_axis_tuser == FUNC_ENCODE);
      s1_flush_d = (s_axis_tuser == FUNC_FLUSH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_enc_q   <= 1'b0;
      s1_flush_q <= 1'b0;
      pend_q     <= '0;
      pcnt_q     <= '0;
      ob_cnt_q   <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s1_enc_q   <= s1_enc_d;
      s1_flush_q <= s1_flush_d;
      pend_q     <= pend_d;
      pcnt_q     <= pcnt_d;
      ob_cnt_q   <= ob_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_data_q <= ob_data_d;
    ob_vb_q   <= ob_vb_d;
  end

  // bytes leave highest first
  assign ob_cm1        = ob_cnt_q[1:0] - 2'd1;
  assign m_axis_tvalid = (ob_cnt_q != 3'd0);
  assign m_axis_tlast  = (ob_cnt_q == 3'd1);
  assign m_axis_tdata  = {4'd0, ob_vb_q, ob_data_q[{ob_cm1, 3'b000} +: ByteBits]};

endmodule

`default_nettype wire

// ----- hw/rtl/hbp_checker.sv -----
// port level checks for the huffman bit packer output channel
// depends on hbp_pkg; bound to huffman_bit_packer_top below
`default_nettype none

module hbp_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          m_axis_tvalid,
  input wire                          m_axis_tready,
  input wire [hbp_pkg::OutDataW-1:0]  m_axis_tdata,
  input wire                          m_axis_tlast
);

  import hbp_pkg::*;

  // valid_bits is always 1..8
  a_vb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[11:8] != 4'd0) && (m_axis_tdata[11:8] <= 4'd8))
    else $error("valid_bits out of range");

  // a partial byte only comes from a flush, which is always the last byte
  a_partial_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[11:8] != 4'd8) |-> m_axis_tlast)
    else $error("partial byte without tlast");

  // padding of a partial byte is zero, at least in bit 0, and unused bits clear
  a_padding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:12] == 4'd0)
      && ((m_axis_tdata[11:8] == 4'd8) || !m_axis_tdata[0]))
    else $error("nonzero padding");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output changed while stalled");

endmodule

bind huffman_bit_packer_top hbp_checker u_hbp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire

// ----- bench/tb.sv -----
// self-checking bench for huffman_bit_packer_top: directed and random requests
// streamed in bursts, packed bytes checked against an in-bench bit packer
// depends on hbp_pkg and the packer rtl
`default_nettype none

module tb;
  import hbp_pkg::*;

  localparam logic [1:0] FuncUnused = 2'd3;

  typedef struct {
    logic [1:0]  func;
    logic [7:0]  sym;
    logic [31:0] code;
    logic [5:0]  len;
    bit          drain;  // hold off until every pending byte has come back
  } packer_req_t;

  typedef struct {
    logic [7:0] data;
    logic [3:0] nbits;
    logic       last;
  } packed_byte_t;

  typedef enum {
    RdyFull,
    RdyRandom,
    RdyPattern,
    RdySparse
  } ready_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  huffman_bit_packer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  packer_req_t  pending_reqs[$];
  packed_byte_t expected_bytes[$];

  // bench copy of the code table and the bit accumulator
  logic [31:0]       tbl_code[256];
  logic [5:0]        tbl_len[256];
  logic [PendW-1:0]  acc_bits = '0;
  logic [2:0]        acc_count = '0;

  bit          sym_loaded[256];
  logic [7:0]  loaded_syms[$];

  int unsigned total_reqs;
  int unsigned accepted_reqs = 0;
  int unsigned mismatch_count = 0;
  logic        in_fire = 1'b0;

  packer_req_t cur_req;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  ready_mode_e ready_mode = RdyFull;
  int unsigned mode_left = 0;
  logic [7:0]  ready_pat = 8'b1011_0110;

  task automatic queue_req(input logic [1:0] func, input logic [7:0] sym,
                           input logic [31:0] code, input logic [5:0] len,
                           input bit drain);
    packer_req_t r;
    r.func  = func;
    r.sym   = sym;
    r.code  = code;
    r.len   = len;
    r.drain = drain;
    pending_reqs.insert(pending_reqs.size(), r);
    if (func == FUNC_LOAD && !sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      loaded_syms.insert(loaded_syms.size(), sym);
    end
  endtask

  function automatic logic [5:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 6'($urandom_range(1, 12));
    else if (r < 85) return 6'($urandom_range(13, 32));
    else if (r < 92) return 6'd0;
    else return 6'($urandom_range(33, 63));
  endfunction

  // load sets the table, encode appends and queues full bytes, flush queues the rest
  task automatic predict_packed_bytes(input logic [1:0] func, input logic [7:0] sym,
                                      input logic [31:0] code, input logic [5:0] len);
    logic [63:0]  acc;
    int unsigned  nlen;
    int unsigned  total;
    packed_byte_t pb;
    case (func)
      FUNC_LOAD: begin
        tbl_code[sym] = code;
        tbl_len[sym]  = (len > LenCap) ? 6'(LenCap) : len;
      end
      FUNC_ENCODE: begin
        nlen  = tbl_len[sym];
        acc   = (64'(acc_bits) << nlen) | (64'(tbl_code[sym]) & ((64'd1 << nlen) - 64'd1));
        total = acc_count + nlen;
        while (total >= ByteBits) begin
          pb.data  = 8'(acc >> (total - ByteBits));
          pb.nbits = 4'(ByteBits);
          pb.last  = (total - ByteBits) < ByteBits;
          expected_bytes.insert(expected_bytes.size(), pb);
          total = total - ByteBits;
        end
        acc_bits  = PendW'(acc & ((64'd1 << total) - 64'd1));
        acc_count = 3'(total);
      end
      FUNC_FLUSH: begin
        if (acc_count != 0) begin
          pb.data  = 8'(16'(acc_bits) << (ByteBits - acc_count));
          pb.nbits = 4'(acc_count);
          pb.last  = 1'b1;
          expected_bytes.insert(expected_bytes.size(), pb);
          acc_bits  = '0;
          acc_count = '0;
        end
      end
      default: ;
    endcase
  endtask

  // request driver: bursts of random length with random gaps
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fire) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain && expected_bytes.size() != 0)) begin
          cur_req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, cur_req.len, cur_req.code, cur_req.sym};
          s_axis_tuser  <= cur_req.func;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
            gap_left   = $urandom_range(0, 6);
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // byte sink back pressure
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 120);
    end
    mode_left = mode_left - 1;
    ready_pat = {ready_pat[6:0], ready_pat[7]};
    case (ready_mode)
      RdyFull:    m_axis_tready <= 1'b1;
      RdyRandom:  m_axis_tready <= ($urandom_range(0, 3) != 0);
      RdyPattern: m_axis_tready <= ready_pat[0];
      default:    m_axis_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // monitor: check the byte leaving first, then predict from the request taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected byte %02h bits %0d last %0b", m_axis_tdata[7:0],
                     m_axis_tdata[11:8], m_axis_tlast);
        end else begin
          if (m_axis_tdata[7:0] !== expected_bytes[0].data ||
              m_axis_tdata[11:8] !== expected_bytes[0].nbits ||
              m_axis_tlast !== expected_bytes[0].last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected byte %02h bits %0d last %0b, got %02h %0d %0b",
                       expected_bytes[0].data, expected_bytes[0].nbits,
                       expected_bytes[0].last, m_axis_tdata[7:0], m_axis_tdata[11:8],
                       m_axis_tlast);
          end
          void'(expected_bytes.pop_front());
        end
      end
      in_fire = s_axis_tvalid && s_axis_tready;
      if (in_fire) begin
        accepted_reqs++;
        predict_packed_bytes(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[39:8],
                             s_axis_tdata[45:40]);
      end
    end
  end

  initial begin
    int unsigned r;
    int unsigned n;
    for (int i = 0; i < 256; i++) begin
      tbl_code[i]   = '0;
      tbl_len[i]    = '0;
      sym_loaded[i] = 1'b0;
    end

    // table extremes, stray code bits, zero and overlong lengths
    queue_req(FUNC_LOAD, 8'd0,   32'h0000_0001, 6'd1,  1'b0);
    queue_req(FUNC_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32, 1'b0);
    queue_req(FUNC_LOAD, 8'd1,   32'hAAAA_AAAA, 6'd5,  1'b0);
    queue_req(FUNC_LOAD, 8'd2,   32'hFFFF_FFFF, 6'd0,  1'b0);
    queue_req(FUNC_LOAD, 8'd3,   32'h1234_5678, 6'd63, 1'b0);
    queue_req(FUNC_LOAD, 8'd4,   32'h0000_0055, 6'd7,  1'b0);
    queue_req(FUNC_LOAD, 8'd5,   32'h0000_00A5, 6'd8,  1'b0);
    queue_req(FUNC_FLUSH, 8'd0, 32'h0, 6'd0, 1'b0);             // nothing pending
    queue_req(FuncUnused, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 1'b0);
    queue_req(FUNC_ENCODE, 8'd0, 32'h0, 6'd0, 1'b0);            // single bit, no byte
    queue_req(FUNC_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 1'b0);
    queue_req(FUNC_ENCODE, 8'd4, 32'h0, 6'd0, 1'b0);            // seven bits left over
    queue_req(FUNC_ENCODE, 8'd255, 32'h0, 6'd0, 1'b0);          // four bytes at once
    queue_req(FUNC_ENCODE, 8'd2, 32'h0, 6'd0, 1'b0);            // empty code
    queue_req(FUNC_ENCODE, 8'd3, 32'h0, 6'd0, 1'b0);
    queue_req(FUNC_ENCODE, 8'd5, 32'h0, 6'd0, 1'b0);
    queue_req(FUNC_ENCODE, 8'd1, 32'h0, 6'd0, 1'b0);
    queue_req(FUNC_FLUSH, 8'd0, 32'h0, 6'd0, 1'b1);
    queue_req(FUNC_LOAD, 8'd0, 32'h0000_0000, 6'd33, 1'b0);     // overwrite, saturates
    queue_req(FUNC_ENCODE, 8'd0, 32'h0, 6'd0, 1'b0);
    queue_req(FUNC_ENCODE, 8'd4, 32'h0, 6'd0, 1'b0);
    queue_req(FUNC_FLUSH, 8'd0, 32'h0, 6'd0, 1'b0);

    // mostly encode runs over loaded symbols, with reloads, flushes and noise
    n = 0;
    while (n < 250) begin
      r = $urandom_range(0, 99);
      if (r < 15 || loaded_syms.size() == 0) begin
        queue_req(FUNC_LOAD, 8'($urandom_range(0, 255)), $urandom, pick_len(), 1'b0);
      end else if (r < 80) begin
        queue_req(FUNC_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                  $urandom, 6'($urandom_range(0, 63)), (n == 0) || ($urandom_range(0, 32) == 0));
      end else if (r < 92) begin
        queue_req(FUNC_FLUSH, 8'($urandom_range(0, 255)), $urandom,
                  6'($urandom_range(0, 63)), 1'b0);
      end else begin
        queue_req(FuncUnused, 8'($urandom_range(0, 255)), $urandom,
                  6'($urandom_range(0, 63)), 1'b0);
      end
      n++;
    end
    total_reqs = pending_reqs.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_reqs == total_reqs);
    wait (expected_bytes.size() == 0);
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
